// ===== rtl/fcsg_pkg.sv =====
// Package: shared types, constants and tables of the filled circle span generator.
`default_nettype none

package fcsg_pkg;

  localparam int MAX_RADIUS = 31;
  localparam int COORD_W    = 16;
  localparam int RAD_W      = 5;
  localparam int LEN_W      = 6;
  localparam int SQ_W       = 11;
  localparam int CNT_W      = 6;
  localparam logic [CNT_W-1:0] MAX_SPANS = 6'd63;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]   radius;
    logic [COORD_W-1:0] fill_color;
  } circle_t;

  typedef struct packed {
    logic [COORD_W-1:0] span_x_start;
    logic [COORD_W-1:0] span_x_end;
    logic [COORD_W-1:0] span_row;
    logic [LEN_W-1:0]   span_length;
    logic [COORD_W-1:0] span_color;
    logic               last_span;
  } span_t;

  // Which span of a circle the datapath builds
  typedef enum logic [2:0] {
    KIND_CENTER,
    KIND_OUTER_P,
    KIND_OUTER_M,
    KIND_INNER_P,
    KIND_INNER_M
  } span_kind_t;

  typedef struct packed {
    logic       load;
    logic       gen;
    span_kind_t kind;
    logic       dec_x;
    logic       inc_i;
    logic       flush;
  } fcsg_cmd_t;

  typedef struct packed {
    logic radius_zero;
    logic shrink;
    logic x_gt_imax;
    logic i_last;
  } fcsg_stat_t;

  typedef logic [RAD_W-1:0] imax_tab_t [MAX_RADIUS+1];

  // Step limit per radius: floor(r * 0.707) + 1
  function automatic imax_tab_t build_imax_tab();
    imax_tab_t tab;
    for (int k = 0; k <= MAX_RADIUS; k++) begin
      tab[k] = RAD_W'((k * 707) / 1000 + 1);
    end
    return tab;
  endfunction

  localparam imax_tab_t IMAX_TAB = build_imax_tab();

endpackage

`default_nettype wire

// ===== rtl/fcsg_ctrl.sv =====
// Controller: sequences the spans of one circle.
`default_nettype none

module fcsg_ctrl
  import fcsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire fcsg_stat_t stat,
  output fcsg_cmd_t       cmd,
  output logic            busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTER,
    S_TEST,
    S_OUTER_P,
    S_OUTER_M,
    S_INNER_P,
    S_INNER_M,
    S_FLUSH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && !stat.radius_zero) begin
            state <= S_CENTER;
            busy  <= 1'b1;
          end
        end
        S_CENTER: state <= S_TEST;
        S_TEST: begin
          if (stat.shrink && stat.x_gt_imax) begin
            state <= S_OUTER_P;
          end else begin
            state <= S_INNER_P;
          end
        end
        S_OUTER_P: state <= S_OUTER_M;
        S_OUTER_M: state <= S_INNER_P;
        S_INNER_P: state <= S_INNER_M;
        S_INNER_M: begin
          if (stat.i_last) begin
            state <= S_FLUSH;
          end else begin
            state <= S_TEST;
          end
        end
        S_FLUSH: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.kind = KIND_CENTER;
    case (state)
      S_IDLE:    cmd.load = start;
      S_CENTER:  cmd.gen = 1'b1;
      S_TEST:    cmd.dec_x = stat.shrink && !stat.x_gt_imax;
      S_OUTER_P: begin
        cmd.gen  = 1'b1;
        cmd.kind = KIND_OUTER_P;
      end
      S_OUTER_M: begin
        cmd.gen   = 1'b1;
        cmd.kind  = KIND_OUTER_M;
        cmd.dec_x = 1'b1;
      end
      S_INNER_P: begin
        cmd.gen  = 1'b1;
        cmd.kind = KIND_INNER_P;
      end
      S_INNER_M: begin
        cmd.gen   = 1'b1;
        cmd.kind  = KIND_INNER_M;
        cmd.inc_i = !stat.i_last;
      end
      S_FLUSH:   cmd.flush = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fcsg_datapath.sv =====
// Datapath: circle step registers, span builder, one-span hold and result register.
`default_nettype none

module fcsg_datapath
  import fcsg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire circle_t   circle,
  input  wire fcsg_cmd_t cmd,
  output fcsg_stat_t     stat,
  output span_t          span,
  output logic           span_valid
);

  logic [COORD_W-1:0] cx, cy, color;
  logic [RAD_W-1:0]   x, i, imax;
  logic [SQ_W-1:0]    sqmax;
  logic [CNT_W-1:0]   count;
  span_t              pend;
  logic               pend_valid;

  logic [SQ_W-1:0]    i_sq, x_sq;
  logic [SQ_W-1:0]    sq_sum;
  logic [RAD_W-1:0]   i_m1;
  span_t              new_span;
  logic               new_ok;

  assign i_sq   = SQ_W'(i) * SQ_W'(i);
  assign x_sq   = SQ_W'(x) * SQ_W'(x);
  assign sq_sum = i_sq + x_sq;
  assign i_m1   = i - 5'd1;

  assign stat.radius_zero = (circle.radius == '0);
  assign stat.shrink      = (sq_sum > sqmax);
  assign stat.x_gt_imax   = (x > imax);
  assign stat.i_last      = (i == imax);

  always_comb begin
    new_span = '0;
    new_span.span_color = color;
    case (cmd.kind)
      KIND_OUTER_P, KIND_OUTER_M: begin
        new_span.span_x_start = cx - COORD_W'(i_m1);
        new_span.span_length  = {i_m1, 1'b0};
        new_span.span_row     = (cmd.kind == KIND_OUTER_P) ? cy + COORD_W'(x)
                                                           : cy - COORD_W'(x);
      end
      KIND_INNER_P: begin
        new_span.span_x_start = cx - COORD_W'(x);
        new_span.span_length  = {x, 1'b0};
        new_span.span_row     = cy + COORD_W'(i);
      end
      KIND_INNER_M: begin
        new_span.span_x_start = cx - COORD_W'(x);
        new_span.span_length  = {x, 1'b0};
        new_span.span_row     = cy - COORD_W'(i);
      end
      default: begin
        new_span.span_x_start = cx - COORD_W'(x);
        new_span.span_length  = {x, 1'b0};
        new_span.span_row     = cy;
      end
    endcase
    new_span.span_x_end = new_span.span_x_start + COORD_W'(new_span.span_length)
                          - 16'd1;
    new_ok = cmd.gen && (new_span.span_length != '0) && (count != MAX_SPANS);
  end

  // Circle registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= circle.center_x;
      cy    <= circle.center_y;
      color <= circle.fill_color;
      x     <= circle.radius;
      i     <= 5'd1;
      imax  <= IMAX_TAB[circle.radius];
      sqmax <= SQ_W'(circle.radius) * SQ_W'(circle.radius) + SQ_W'(circle.radius >> 1);
    end else begin
      if (cmd.dec_x && x != '0) begin
        x <= x - 5'd1;
      end
      if (cmd.inc_i) begin
        i <= i + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count <= '0;
    end else if (new_ok) begin
      count <= count + 6'd1;
    end
  end

  // Hold one span back so the final one can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      span_valid <= 1'b0;
    end else begin
      span_valid <= 1'b0;
      if (new_ok) begin
        pend       <= new_span;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          span       <= pend;
          span_valid <= 1'b1;
        end
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
        if (pend_valid) begin
          // last_span is the lowest bit of the packed span
          span       <= {pend[$bits(span_t)-1:1], 1'b1};
          span_valid <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/filled_circle_span_generator.sv =====
// Top level of the filled circle span generator.
`default_nettype none

// Channel   Ports                      Transaction
// -------   -------------------------  ------------------------------------------
// circle    start, busy, circle        taken at a rising edge with start & !busy
// span      span_valid, span           one span per strobe cycle, cannot be held
//
// Sequence: the center row, then per step of i a test state, an outer row pair when
//   x has to shrink and x > imax = floor(0.707r)+1, and an inner row pair. The
//   controller walks one span per cycle in its span states.
// Radius zero: the transaction is taken and busy never rises; no span is emitted.
// Reset: rst clears the controller and the result strobe; payload registers hold.
// Stalls: the receiver cannot stall; each span leaves when the next kept one is
//   built, the last one after the flush state that marks it.
module filled_circle_span_generator
  import fcsg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire circle_t circle,
  output logic         span_valid,
  output span_t        span
);

  fcsg_cmd_t  cmd;
  fcsg_stat_t stat;

  // Sequence center row, outer row pairs and inner row pairs
  fcsg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the circle, advance x and i, build and drop spans, mark the last one
  fcsg_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .circle     (circle),
    .cmd        (cmd),
    .stat       (stat),
    .span       (span),
    .span_valid (span_valid)
  );

  // A span that is not the last must leave the block still working on its circle
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    span_valid && !span.last_span |-> busy)
    else $error("non-final span emitted with block idle");

  // Zero-length spans are dropped and lengths stay within the diameter
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> (span.span_length != '0) && (span.span_length <= 6'd62))
    else $error("span length out of range");

  // End column follows start column and length
  a_end_col: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> span.span_x_end ==
      span.span_x_start + COORD_W'(span.span_length) - 16'd1)
    else $error("span end column mismatch");

  // Zero radius never makes the block busy
  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (circle.radius == '0) |=> !busy)
    else $error("zero radius made the block busy");

endmodule

`default_nettype wire

// ===== dv/filled_circle_span_generator_tb.sv =====
// Self-checking testbench for the filled circle span generator.
`timescale 1ns / 1ps

module filled_circle_span_generator_tb;
  import fcsg_pkg::*;

  // Step limit of the scan is floor(r * 707 / 1000) + 1
  localparam int unsigned STEP_NUM = 707;
  localparam int unsigned STEP_DEN = 1000;

  // Time allowed for a full run before it is declared hung
  localparam int unsigned RUN_LIMIT_NS = 3_000_000;

  // Cycles to watch after the last span for stray ones
  localparam int unsigned TAIL_CYCLES = 120;

  localparam int unsigned RANDOM_CIRCLES = 350;

  // Span predictor and in-order checker
  class span_board;
    span_t pending_spans[$];
    span_t circle_spans[$];
    int    mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Append one span of the circle being built; drop empty spans
    function void push_span(logic [15:0] xs, logic [15:0] row, int unsigned len,
                            logic [15:0] color);
      span_t s;
      if (len == 0) begin
        return;
      end
      s.span_x_start = xs;
      s.span_x_end   = 16'(xs + len - 1);
      s.span_row     = row;
      s.span_length  = LEN_W'(len);
      s.span_color   = color;
      s.last_span    = 1'b0;
      circle_spans.push_back(s);
    endfunction

    // Work out every span of an accepted circle and queue them in emit order
    function void add_circle(circle_t c);
      int unsigned r;
      int unsigned imax;
      int unsigned sqmax;
      int unsigned x;
      circle_spans.delete();
      r = c.radius;
      if (r > MAX_RADIUS) begin
        r = MAX_RADIUS;
      end
      if (r == 0) begin
        return;
      end
      imax  = (r * STEP_NUM) / STEP_DEN + 1;
      sqmax = r * r + r / 2;
      x     = r;
      push_span(16'(c.center_x - r), c.center_y, 2 * r, c.fill_color);
      for (int unsigned i = 1; i <= imax; i++) begin
        if (i * i + x * x > sqmax) begin
          // Outer rows only while the half-width is still beyond the step limit
          if (x > imax) begin
            push_span(16'(c.center_x - i + 1), 16'(c.center_y + x), 2 * (i - 1),
                      c.fill_color);
            push_span(16'(c.center_x - i + 1), 16'(c.center_y - x), 2 * (i - 1),
                      c.fill_color);
          end
          if (x > 0) begin
            x--;
          end
        end
        push_span(16'(c.center_x - x), 16'(c.center_y + i), 2 * x, c.fill_color);
        push_span(16'(c.center_x - x), 16'(c.center_y - i), 2 * x, c.fill_color);
      end
      if (circle_spans.size() > 0) begin
        circle_spans[circle_spans.size() - 1].last_span = 1'b1;
      end
      foreach (circle_spans[k]) begin
        pending_spans.push_back(circle_spans[k]);
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t ns: span mismatch on %s: expected 0x%0h, got 0x%0h",
                 $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    // Check one strobed span against the oldest expected one
    function void check_span(span_t got);
      span_t want;
      if (pending_spans.size() == 0) begin
        $display("%0t ns: unexpected span, none pending: got %p", $time, got);
        mismatch_count++;
        return;
      end
      want = pending_spans.pop_front();
      compare_field("span_x_start", want.span_x_start, got.span_x_start);
      compare_field("span_x_end",   want.span_x_end,   got.span_x_end);
      compare_field("span_row",     want.span_row,     got.span_row);
      compare_field("span_length",  want.span_length,  got.span_length);
      compare_field("span_color",   want.span_color,   got.span_color);
      compare_field("last_span",    want.last_span,    got.last_span);
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  circle_t circle;
  logic    span_valid;
  span_t   span;

  span_board board = new();

  filled_circle_span_generator u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .circle     (circle),
    .span_valid (span_valid),
    .span       (span)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = ~clk;
    end
  end

  // Hang guard: a correct run ends far earlier
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  // Spans cannot be held off, so check every strobe at the edge that ends it.
  // Values read here are the ones before the edge updates them.
  always @(posedge clk) begin
    if (!rst && span_valid) begin
      board.check_span(span);
    end
  end

  function automatic circle_t make_circle(logic [15:0] cx, logic [15:0] cy,
                                          logic [4:0] r, logic [15:0] color);
    circle_t c;
    c.center_x   = cx;
    c.center_y   = cy;
    c.radius     = r;
    c.fill_color = color;
    return c;
  endfunction

  // Present a circle from a falling edge and hold it until a rising edge takes
  // the transaction (start high, busy low). Return on the next falling edge
  // with start still high, so a back-to-back transaction needs no toggle.
  task automatic send_circle(circle_t c);
    start  = 1'b1;
    circle = c;
    forever begin
      @(posedge clk);
      if (!busy) begin
        break;
      end
    end
    board.add_circle(c);
    @(negedge clk);
  endtask

  // Drop start for a random number of cycles: mostly none or short, a few long.
  // A zero gap keeps start high for the next transaction.
  task automatic idle_gap(bit no_idle);
    int unsigned pick;
    int unsigned cycles;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 45) begin
      cycles = 0;
    end else if (pick < 85) begin
      cycles = $urandom_range(1, 3);
    end else if (pick < 97) begin
      cycles = $urandom_range(4, 15);
    end else begin
      cycles = $urandom_range(20, 60);
    end
    if (cycles > 0) begin
      start  = 1'b0;
      circle = make_circle(16'($urandom), 16'($urandom), 5'($urandom), 16'($urandom));
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Center coordinate: mostly anywhere, sometimes hugging either end so that
  // columns and rows wrap around
  function automatic logic [15:0] pick_coord();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return 16'($urandom);
    end else if (pick < 82) begin
      return 16'($urandom_range(0, 40));
    end else begin
      return 16'($urandom_range(65495, 65535));
    end
  endfunction

  initial begin
    circle_t c;
    bit      no_idle;

    rst    = 1'b1;
    start  = 1'b0;
    circle = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: smallest and largest radii, zero radius, wrap at both ends
    // of the coordinate range, color extremes
    send_circle(make_circle(16'd100, 16'd100, 5'd1, 16'h1234));
    send_circle(make_circle(16'd200, 16'd50, 5'd2, 16'h0000));
    send_circle(make_circle(16'h8000, 16'h8000, 5'd31, 16'hFFFF));
    send_circle(make_circle(16'h1357, 16'h2468, 5'd0, 16'hA5A5));
    idle_gap(1'b0);
    send_circle(make_circle(16'h0000, 16'h0000, 5'd31, 16'h0000));
    send_circle(make_circle(16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF));
    send_circle(make_circle(16'h0005, 16'hFFFC, 5'd7, 16'hF800));
    send_circle(make_circle(16'hFFFF, 16'hFFFF, 5'd0, 16'hFFFF));
    send_circle(make_circle(16'h0000, 16'h0000, 5'd0, 16'h0000));
    send_circle(make_circle(16'hFFFE, 16'h0001, 5'd3, 16'h07E0));
    idle_gap(1'b0);
    send_circle(make_circle(16'd1000, 16'd1000, 5'd4, 16'h001F));
    send_circle(make_circle(16'd1000, 16'd1000, 5'd5, 16'h5555));
    send_circle(make_circle(16'd30, 16'd65500, 5'd8, 16'hAAAA));
    send_circle(make_circle(16'd65530, 16'd20, 5'd15, 16'h0F0F));
    send_circle(make_circle(16'd16, 16'd16, 5'd16, 16'hF0F0));
    send_circle(make_circle(16'h7FFF, 16'h8000, 5'd30, 16'h8001));
    idle_gap(1'b0);

    // Random part; every third block of 40 runs with start held high
    for (int n = 0; n < RANDOM_CIRCLES; n++) begin
      no_idle = ((n / 40) % 3) == 2;
      c = make_circle(pick_coord(), pick_coord(), 5'($urandom_range(0, 31)),
                      16'($urandom));
      send_circle(c);
      idle_gap(no_idle);
    end
    start = 1'b0;

    // Drain: wait for every expected span, then watch for stray ones
    while (board.pending_spans.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.mismatch_count == 0 && board.pending_spans.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
